// ----- sv/mse_pkg.sv -----
// Shared types and codes for the M-spline series evaluator.
package mse_pkg;

   // func codes
   localparam logic [1:0] FN_LOAD_KNOT = 2'd0;
   localparam logic [1:0] FN_LOAD_COEF = 2'd1;
   localparam logic [1:0] FN_SUM       = 2'd2;
   localparam logic [1:0] FN_TERMS     = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_SAT     = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_DEGREE     = 2'd0;
   localparam logic [1:0] CSR_KNOT_COUNT = 2'd1;
   localparam logic [1:0] CSR_COEF_COUNT = 2'd2;

   localparam logic [2:0] DEGREE_RST     = 3'd3;
   localparam logic [5:0] KNOT_COUNT_RST = 6'd3;
   localparam logic [5:0] COEF_COUNT_RST = 6'd5;

   typedef struct packed {
      logic [1:0]         func;
      logic [5:0]         slot_index;
      logic signed [31:0] load_value;
      logic signed [31:0] position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [5:0]         term_index;
      logic               is_last;
      logic [1:0]         status;
   } rsp_type;

endpackage

// ----- sv/mspline_series_evaluator_top.sv -----
// M-spline series evaluator: knot/coefficient tables, recursion sequencer, shared mul/div.
//
// A transfer is taken when start is high and busy is low. Knot and coefficient loads
// complete in the cycle they are taken and give no result. An evaluate transfer keeps
// busy high until its last result has been driven; results appear on rsp_data for
// one cycle each with rsp_strobe, and the receiver cannot stall them. Every step of the
// basis recursion runs on one shift-add multiplier (AW-bit operand, stopping early once
// the operand runs out of ones) and one restoring divider (NW-bit numerator), where
// AW = 33+clog2(MAX_DEGREE+2)+1 and NW = AW+50+clog2(MAX_KNOTS+MAX_DEGREE). Each basis
// function of order p = degree+1 costs up to p divisions at the first level and
// p(p-1)/2 divisions plus twice as many multiplications at the higher levels, a few
// knot-table reads per step, plus one more multiply (sum mode) or divide (terms mode)
// per term.
module mspline_series_evaluator_top #(
   parameter int MAX_DEGREE = 7,
   parameter int MAX_KNOTS  = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mse_pkg::req_type req_data,
   output logic            rsp_strobe,
   output mse_pkg::rsp_type rsp_data,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [5:0]      csr_wdata
);
   import mse_pkg::*;

   localparam int CDEPTH = MAX_KNOTS + MAX_DEGREE - 1;
   localparam int SDEPTH = MAX_DEGREE + 2;
   localparam int KAW = $clog2(MAX_KNOTS);
   localparam int CAW = $clog2(CDEPTH);
   localparam int SAW = $clog2(SDEPTH);
   localparam int IW  = $clog2(MAX_KNOTS + 2 * MAX_DEGREE + 4) + 2;
   localparam int KW  = $clog2(MAX_DEGREE + 2) + 1;
   localparam int AW  = 33 + KW;                 // multiplier operand a
   localparam int DW  = 33 + KW;                 // divisor
   localparam int PW  = AW + 48;                 // product magnitude
   localparam int NW  = PW + 2 + $clog2(CDEPTH + 1);  // numerator / accumulator
   localparam int CW  = $clog2(NW);

   localparam logic [NW-1:0] ONE_Q48 = NW'(1) << 48;

   // sequencer states
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_LO   = 5'd1;
   localparam logic [4:0] ST_HI   = 5'd2;
   localparam logic [4:0] ST_TERM = 5'd3;
   localparam logic [4:0] ST_COEF = 5'd4;
   localparam logic [4:0] ST_SP0  = 5'd5;
   localparam logic [4:0] ST_SP1  = 5'd6;
   localparam logic [4:0] ST_SP2  = 5'd7;
   localparam logic [4:0] ST_L1A  = 5'd8;
   localparam logic [4:0] ST_L1B  = 5'd9;
   localparam logic [4:0] ST_L1C  = 5'd10;
   localparam logic [4:0] ST_L1W  = 5'd11;
   localparam logic [4:0] ST_LVA  = 5'd12;
   localparam logic [4:0] ST_LVB  = 5'd13;
   localparam logic [4:0] ST_LVC  = 5'd14;
   localparam logic [4:0] ST_LVD  = 5'd15;
   localparam logic [4:0] ST_LVE  = 5'd16;
   localparam logic [4:0] ST_LVF  = 5'd17;
   localparam logic [4:0] ST_LVG  = 5'd18;
   localparam logic [4:0] ST_LVW  = 5'd19;
   localparam logic [4:0] ST_FIN  = 5'd20;
   localparam logic [4:0] ST_FIN2 = 5'd21;
   localparam logic [4:0] ST_BAS  = 5'd22;
   localparam logic [4:0] ST_SUMN = 5'd23;
   localparam logic [4:0] ST_TOUT = 5'd24;
   localparam logic [4:0] ST_SOUT = 5'd25;
   localparam logic [4:0] ST_MUL  = 5'd26;
   localparam logic [4:0] ST_DIV  = 5'd27;
   localparam logic [4:0] ST_DIVF = 5'd28;

   // config
   logic [2:0] degree_ff, degree_in;
   logic [5:0] knot_count_ff, knot_count_in;
   logic [5:0] coef_count_ff, coef_count_in;

   // control
   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   logic       strobe_ff, strobe_in;
   rsp_type    rsp_ff, rsp_in;

   // tables
   logic signed [31:0] knot_mem_ff [MAX_KNOTS];
   logic [MAX_KNOTS-1:0] knot_vld_ff, knot_vld_in;
   logic signed [31:0] coef_mem_ff [CDEPTH];
   logic [CDEPTH-1:0] coef_vld_ff, coef_vld_in;
   logic signed [47:0] scr_mem_ff [SDEPTH];
   logic signed [31:0] kmem_q_ff, cmem_q_ff;
   logic kval_q_ff, cval_q_ff;
   logic signed [47:0] sd_ff;

   // datapath
   logic signed [31:0] x_ff, x_in, lo_ff, lo_in, p1_ff, p1_in, p2_ff, p2_in, c_ff, c_in;
   logic sum_ff, sum_in, sat_ff, sat_in;
   logic signed [IW-1:0] i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic signed [DW-1:0] den_ff, den_in;
   logic signed [NW-1:0] num_ff, num_in, acc_ff, acc_in;
   logic signed [47:0] basis_ff, basis_in, divres_ff, divres_in;

   // multiplier
   logic [AW-1:0] ma_ff, ma_in;
   logic [PW-1:0] mb_ff, mb_in, prod_ff, prod_in;
   logic mneg_ff, mneg_in, acc_sel_ff, acc_sel_in;

   // divider
   logic [NW-1:0] dn_ff, dn_in;
   logic [DW-1:0] dd_ff, dd_in, rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic dneg_ff, dneg_in, w48_ff, w48_in;

   // comb helpers
   logic accept;
   logic [KAW+5:0] kslot;
   logic [CAW+5:0] cslot;
   logic signed [IW-1:0] kidx, deg_raw, deg_e, order, nk_raw, nk, cc_raw, cc;
   logic signed [IW-1:0] ib, ie, ib_t, ie_t, mn, l1k1, l1k2, lk1, lk2, jmax;
   logic [KAW-1:0] kaddr;
   logic [CAW-1:0] caddr;
   logic signed [31:0] kv, cv;
   logic signed [32:0] dx1, dx2, gap;
   logic signed [KW-1:0] kk, km1;
   logic s_re, s_we;
   logic [SAW-1:0] s_ra, s_wa;
   logic signed [47:0] s_wd;
   logic step_k, step_j, step_i;
   logic mul_go, mul_to_acc;
   logic signed [AW-1:0] mul_a;
   logic signed [47:0] mul_b;
   logic [47:0] mbm;
   logic [4:0] mul_ret, div_ret;
   logic signed [NW-1:0] psig, div_num;
   logic div_go, div_w48;
   logic signed [DW-1:0] div_den;
   logic [NW-1:0] nm, lim, q;
   logic [DW-1:0] dm;
   logic [DW:0] rs, rsub;
   logic ge;
   logic signed [47:0] qs;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

   assign kslot = {{KAW{1'b0}}, req_data.slot_index};
   assign cslot = {{CAW{1'b0}}, req_data.slot_index};

   // effective (clamped) configuration
   always_comb begin
      deg_raw = $signed(IW'(degree_ff));
      deg_e = (deg_raw > IW'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : deg_raw;
      order = deg_e + IW'(1);
      nk_raw = $signed(IW'(knot_count_ff));
      nk = (nk_raw < IW'(3)) ? IW'(3) : ((nk_raw > IW'(MAX_KNOTS)) ? IW'(MAX_KNOTS) : nk_raw);
      cc_raw = $signed(IW'(coef_count_ff));
      cc = (cc_raw < IW'(1)) ? IW'(1) : ((cc_raw > IW'(CDEPTH)) ? IW'(CDEPTH) : cc_raw);
   end

   // knot index arithmetic of the recursion
   always_comb begin
      ib_t = i_ff - order + IW'(1);
      ib = (ib_t < IW'(1)) ? IW'(1) : ib_t;
      mn = (i_ff < order) ? i_ff : order;
      ie_t = ib + mn;
      ie = (ie_t > nk) ? nk : ie_t;
      l1k1 = i_ff - order + k_ff;
      l1k2 = l1k1 + IW'(1);
      lk1 = i_ff - order + j_ff;
      lk2 = lk1 + k_ff;
      // end-knot clipping
      if (lk2 > IW'(1) && lk1 < IW'(1)) begin
         lk1 = IW'(1);
      end else if (lk2 > nk && lk1 < nk) begin
         lk2 = nk;
      end
      jmax = order - k_ff + IW'(1);
      kk = KW'(k_ff);
      km1 = KW'(k_ff - IW'(1));
   end

   assign kv = kval_q_ff ? kmem_q_ff : 32'sd0;
   assign cv = cval_q_ff ? cmem_q_ff : 32'sd0;
   assign kaddr = KAW'(kidx - IW'(1));
   assign caddr = CAW'(i_ff - IW'(1));
   assign dx1 = {x_ff[31], x_ff} - {p1_ff[31], p1_ff};
   assign dx2 = {p2_ff[31], p2_ff} - {x_ff[31], x_ff};
   assign gap = {kv[31], kv} - {p1_ff[31], p1_ff};

   // config and valid bits
   always_comb begin
      degree_in = degree_ff;
      knot_count_in = knot_count_ff;
      coef_count_in = coef_count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEGREE:     degree_in = csr_wdata[2:0];
            CSR_KNOT_COUNT: knot_count_in = csr_wdata;
            CSR_COEF_COUNT: coef_count_in = csr_wdata;
            default:        ;
         endcase
      end
      knot_vld_in = knot_vld_ff;
      coef_vld_in = coef_vld_ff;
      if (accept && req_data.func == FN_LOAD_KNOT && 32'(req_data.slot_index) < MAX_KNOTS) begin
         knot_vld_in[kslot[KAW-1:0]] = 1'b1;
      end
      if (accept && req_data.func == FN_LOAD_COEF && 32'(req_data.slot_index) < CDEPTH) begin
         coef_vld_in[cslot[CAW-1:0]] = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      strobe_in = 1'b0;
      rsp_in = rsp_ff;
      x_in = x_ff; lo_in = lo_ff; p1_in = p1_ff; p2_in = p2_ff; c_in = c_ff;
      sum_in = sum_ff; sat_in = sat_ff;
      i_in = i_ff; k_in = k_ff; j_in = j_ff;
      den_in = den_ff; num_in = num_ff; acc_in = acc_ff;
      basis_in = basis_ff; divres_in = divres_ff;
      ma_in = ma_ff; mb_in = mb_ff; prod_in = prod_ff; mneg_in = mneg_ff; acc_sel_in = acc_sel_ff;
      dn_in = dn_ff; dd_in = dd_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      dneg_in = dneg_ff; w48_in = w48_ff;
      kidx = IW'(1);
      s_re = 1'b0; s_ra = '0; s_we = 1'b0; s_wa = '0; s_wd = '0;
      step_k = 1'b0; step_j = 1'b0; step_i = 1'b0;
      mul_go = 1'b0; mul_a = '0; mul_b = '0; mul_to_acc = 1'b0; mul_ret = ST_IDLE;
      div_go = 1'b0; div_num = '0; div_den = '0; div_w48 = 1'b0; div_ret = ST_IDLE;
      psig = '0; nm = '0; dm = '0; lim = '0; q = '0; qs = '0; mbm = '0;
      rs = '0; rsub = '0; ge = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_data.func == FN_SUM || req_data.func == FN_TERMS)) begin
               x_in = req_data.position;
               sum_in = (req_data.func == FN_SUM);
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            lo_in = kv;
            kidx = nk;
            state_in = ST_HI;
         end
         ST_HI: begin
            if (x_ff < lo_ff || x_ff > kv) begin
               rsp_in.value = '0;
               rsp_in.term_index = '0;
               rsp_in.is_last = 1'b1;
               rsp_in.status = STAT_OUTSIDE;
               strobe_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               i_in = IW'(1);
               acc_in = '0;
               sat_in = 1'b0;
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            if (!sum_ff) sat_in = 1'b0;
            state_in = ST_COEF;
         end
         ST_COEF: begin
            c_in = cv;
            if (sum_ff && cv == 32'sd0) begin
               step_i = 1'b1;
            end else begin
               state_in = ST_SP0;
            end
         end
         ST_SP0: begin
            if (i_ff > nk + order - IW'(2)) begin
               basis_in = '0;
               state_in = ST_BAS;
            end else begin
               kidx = ib;
               state_in = ST_SP1;
            end
         end
         ST_SP1: begin
            if (x_ff < kv) begin
               basis_in = '0;
               state_in = ST_BAS;
            end else begin
               kidx = ie;
               state_in = ST_SP2;
            end
         end
         ST_SP2: begin
            if (x_ff > kv) begin
               basis_in = '0;
               state_in = ST_BAS;
            end else begin
               k_in = IW'(1);
               state_in = ST_L1A;
            end
         end
         ST_L1A: begin
            if (l1k1 > IW'(0) && l1k2 <= nk) begin
               kidx = l1k1;
               state_in = ST_L1B;
            end else begin
               s_we = 1'b1; s_wa = SAW'(k_ff); s_wd = '0;
               step_k = 1'b1;
            end
         end
         ST_L1B: begin
            p1_in = kv;
            kidx = l1k2;
            state_in = ST_L1C;
         end
         ST_L1C: begin
            if (x_ff >= p1_ff && x_ff < kv) begin
               div_go = 1'b1;
               div_num = ONE_Q48;
               div_den = DW'(gap);
               div_w48 = 1'b1;
               div_ret = ST_L1W;
            end else begin
               s_we = 1'b1; s_wa = SAW'(k_ff); s_wd = '0;
               step_k = 1'b1;
            end
         end
         ST_L1W: begin
            s_we = 1'b1; s_wa = SAW'(k_ff); s_wd = divres_ff;
            step_k = 1'b1;
         end
         ST_LVA: begin
            if (lk1 > IW'(0) && lk2 <= nk) begin
               kidx = lk1;
               state_in = ST_LVB;
            end else begin
               step_j = 1'b1;
            end
         end
         ST_LVB: begin
            p1_in = kv;
            kidx = lk2;
            state_in = ST_LVC;
         end
         ST_LVC: begin
            p2_in = kv;
            den_in = DW'(gap) * DW'(km1);
            s_re = 1'b1; s_ra = SAW'(j_ff);
            state_in = ST_LVD;
         end
         ST_LVD: begin
            if (den_ff == '0) begin
               s_we = 1'b1; s_wa = SAW'(j_ff); s_wd = '0;
               step_j = 1'b1;
            end else begin
               num_in = '0;
               mul_go = 1'b1;
               mul_a = AW'(dx1) * AW'(kk);
               mul_b = sd_ff;
               mul_ret = ST_LVE;
            end
         end
         ST_LVE: begin
            s_re = 1'b1; s_ra = SAW'(j_ff + IW'(1));
            state_in = ST_LVF;
         end
         ST_LVF: begin
            mul_go = 1'b1;
            mul_a = AW'(dx2) * AW'(kk);
            mul_b = sd_ff;
            mul_ret = ST_LVG;
         end
         ST_LVG: begin
            div_go = 1'b1;
            div_num = num_ff;
            div_den = den_ff;
            div_w48 = 1'b1;
            div_ret = ST_LVW;
         end
         ST_LVW: begin
            s_we = 1'b1; s_wa = SAW'(j_ff); s_wd = divres_ff;
            step_j = 1'b1;
         end
         ST_FIN: begin
            s_re = 1'b1; s_ra = SAW'(1);
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            basis_in = sd_ff;
            state_in = ST_BAS;
         end
         ST_BAS: begin
            if (sum_ff) begin
               mul_go = 1'b1;
               mul_a = AW'(c_ff);
               mul_b = basis_ff;
               mul_to_acc = 1'b1;
               mul_ret = ST_SUMN;
            end else begin
               div_go = 1'b1;
               div_num = NW'(basis_ff);
               div_den = DW'(65536);
               div_ret = ST_TOUT;
            end
         end
         ST_SUMN: step_i = 1'b1;
         ST_TOUT: begin
            rsp_in.value = divres_ff[31:0];
            rsp_in.term_index = 6'(i_ff - IW'(1));
            rsp_in.is_last = (i_ff == cc);
            rsp_in.status = sat_ff ? STAT_SAT : STAT_OK;
            strobe_in = 1'b1;
            if (i_ff == cc) begin
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + IW'(1);
               state_in = ST_TERM;
            end
         end
         ST_SOUT: begin
            rsp_in.value = divres_ff[31:0];
            rsp_in.term_index = '0;
            rsp_in.is_last = 1'b1;
            rsp_in.status = sat_ff ? STAT_SAT : STAT_OK;
            strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            // shift-add, stops once the remaining operand bits are zero
            if (ma_ff == '0) begin
               psig = $signed(NW'(prod_ff));
               if (mneg_ff) psig = -psig;
               if (acc_sel_ff) acc_in = acc_ff + psig;
               else num_in = num_ff + psig;
               state_in = ret_ff;
            end else begin
               if (ma_ff[0]) prod_in = prod_ff + mb_ff;
               mb_in = mb_ff << 1;
               ma_in = ma_ff >> 1;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            rs = {rem_ff, dn_ff[NW-1]};
            rsub = rs - {1'b0, dd_ff};
            ge = (rs >= {1'b0, dd_ff});
            rem_in = ge ? rsub[DW-1:0] : rs[DW-1:0];
            dn_in = {dn_ff[NW-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) state_in = ST_DIVF;
         end
         ST_DIVF: begin
            lim = (w48_ff ? (NW'(1) << 47) : (NW'(1) << 31)) - NW'(!dneg_ff);
            q = dn_ff;
            if (q > lim) begin
               q = lim;
               sat_in = 1'b1;
            end
            qs = q[47:0];
            divres_in = dneg_ff ? -qs : qs;
            state_in = ret_ff;
         end
         default: state_in = ST_IDLE;
      endcase

      if (step_k) begin
         if (k_ff == order) begin
            k_in = IW'(2);
            j_in = IW'(1);
            state_in = (order < IW'(2)) ? ST_FIN : ST_LVA;
         end else begin
            k_in = k_ff + IW'(1);
            state_in = ST_L1A;
         end
      end
      if (step_j) begin
         if (j_ff == jmax) begin
            if (k_ff == order) begin
               state_in = ST_FIN;
            end else begin
               k_in = k_ff + IW'(1);
               j_in = IW'(1);
               state_in = ST_LVA;
            end
         end else begin
            j_in = j_ff + IW'(1);
            state_in = ST_LVA;
         end
      end
      if (step_i) begin
         if (i_ff == cc) begin
            // final rescale of the Q.48 accumulation
            div_go = 1'b1;
            div_num = acc_ff;
            div_den = DW'(1) << 32;
            div_ret = ST_SOUT;
         end else begin
            i_in = i_ff + IW'(1);
            state_in = ST_TERM;
         end
      end
      if (mul_go) begin
         mneg_in = mul_a[AW-1] ^ mul_b[47];
         ma_in = mul_a[AW-1] ? AW'(-mul_a) : AW'(mul_a);
         mbm = mul_b[47] ? 48'(-mul_b) : 48'(mul_b);
         mb_in = PW'(mbm);
         prod_in = '0;
         acc_sel_in = mul_to_acc;
         ret_in = mul_ret;
         state_in = ST_MUL;
      end
      if (div_go) begin
         nm = div_num[NW-1] ? NW'(-div_num) : NW'(div_num);
         dm = div_den[DW-1] ? DW'(-div_den) : DW'(div_den);
         dn_in = nm + NW'(dm >> 1);
         dd_in = dm;
         rem_in = '0;
         cnt_in = '0;
         dneg_in = div_num[NW-1] ^ div_den[DW-1];
         w48_in = div_w48;
         ret_in = div_ret;
         state_in = ST_DIV;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         strobe_ff <= 1'b0;
         degree_ff <= DEGREE_RST;
         knot_count_ff <= KNOT_COUNT_RST;
         coef_count_ff <= COEF_COUNT_RST;
         knot_vld_ff <= '0;
         coef_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
         degree_ff <= degree_in;
         knot_count_ff <= knot_count_in;
         coef_count_ff <= coef_count_in;
         knot_vld_ff <= knot_vld_in;
         coef_vld_ff <= coef_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ret_ff <= ret_in; rsp_ff <= rsp_in;
      x_ff <= x_in; lo_ff <= lo_in; p1_ff <= p1_in; p2_ff <= p2_in; c_ff <= c_in;
      sum_ff <= sum_in; sat_ff <= sat_in;
      i_ff <= i_in; k_ff <= k_in; j_ff <= j_in;
      den_ff <= den_in; num_ff <= num_in; acc_ff <= acc_in;
      basis_ff <= basis_in; divres_ff <= divres_in;
      ma_ff <= ma_in; mb_ff <= mb_in; prod_ff <= prod_in;
      mneg_ff <= mneg_in; acc_sel_ff <= acc_sel_in;
      dn_ff <= dn_in; dd_ff <= dd_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      dneg_ff <= dneg_in; w48_ff <= w48_in;
   end

   // knot and coefficient tables, registered reads
   always_ff @(posedge clock) begin
      if (accept && req_data.func == FN_LOAD_KNOT && 32'(req_data.slot_index) < MAX_KNOTS) begin
         knot_mem_ff[kslot[KAW-1:0]] <= req_data.load_value;
      end
      if (accept && req_data.func == FN_LOAD_COEF && 32'(req_data.slot_index) < CDEPTH) begin
         coef_mem_ff[cslot[CAW-1:0]] <= req_data.load_value;
      end
      kmem_q_ff <= knot_mem_ff[kaddr];
      kval_q_ff <= knot_vld_ff[kaddr];
      cmem_q_ff <= coef_mem_ff[caddr];
      cval_q_ff <= coef_vld_ff[caddr];
   end

   // recursion scratch
   always_ff @(posedge clock) begin
      if (s_we) scr_mem_ff[s_wa] <= s_wd;
      if (s_re) sd_ff <= scr_mem_ff[s_ra];
   end

endmodule

// ----- sv/mse_checker.sv -----
// Port-level checks for the M-spline series evaluator, bound to the top level.
module mse_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mse_pkg::req_type req_data,
   input logic             rsp_strobe,
   input mse_pkg::rsp_type rsp_data
);
   import mse_pkg::*;

   // results only come out of an evaluation in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result transfer without an evaluation in progress");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.is_last |-> !busy)
      else $error("still busy after the last result");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.is_last |-> busy)
      else $error("idle before the last result");

   a_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STAT_OUTSIDE |->
         rsp_data.value == 32'sd0 && rsp_data.term_index == 6'd0 && rsp_data.is_last)
      else $error("malformed out-of-domain result");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.func == FN_SUM || req_data.func == FN_TERMS) |=> busy)
      else $error("evaluation taken without going busy");

endmodule

bind mspline_series_evaluator_top mse_checker u_mse_checker (.*);
